>>> sv/nlfc_pkg.sv
// ----------------------------------------------------------------------------
// nlfc_pkg: shared types and constants of the NMEA line framer
// Character codes, header signatures, result codes and the line class type.
// ----------------------------------------------------------------------------
package nlfc_pkg;

   localparam logic [7:0] CH_DOLLAR   = 8'h24;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_ASTERISK = 8'h2A;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_ONE      = 8'h31;

   // Header signatures, compared against the bytes that follow the '$'.
   localparam logic [31:0] SIG_PQTM    = "PQTM";
   localparam logic [31:0] SIG_PAIR    = "PAIR";
   localparam logic [55:0] SIG_PAIR001 = "PAIR001";
   localparam logic [23:0] SIG_RMC     = "RMC";
   localparam logic [23:0] SIG_GGA     = "GGA";

   localparam int HDR_DEPTH   = 7;
   localparam int MIN_LEN     = 6;
   localparam int STATUS_POS  = 13;
   localparam int LEN_W       = 7;
   localparam int LEN_MAX     = 127;

   localparam logic EV_LINE     = 1'b0;
   localparam logic EV_OVERFLOW = 1'b1;

   typedef enum logic [1:0] {
      LC_INVALID  = 2'd0,
      LC_VENDOR   = 2'd1,
      LC_STANDARD = 2'd2
   } line_class_type;

endpackage

>>> sv/nmea_line_framer_classifier.sv
// ----------------------------------------------------------------------------
// nmea_line_framer_classifier: NMEA sentence framer and classifier
// Frames '$'-started lines from a received byte stream and classifies them.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle and gives a result only
// for a line feed that closes a line which fit in the buffer, or once for a
// line that outgrew it. The line state is updated in the cycle a byte is
// transferred in, and the result appears in the output register on the next
// cycle; that output register is the only place the block can stall, so
// bytes keep flowing every cycle unless a result waits while rsp_stall is
// high. A '$' restarts a line at any time, carriage returns are ignored, and
// bytes outside a line are dropped. Only the header bytes, the status digit
// and an asterisk flag are kept, so the buffer length is just a counter.
module nmea_line_framer_classifier #(
   parameter int LINE_BUF_SIZE = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_event_kind,
   output logic [1:0] rsp_line_class,
   output logic       rsp_is_rmc,
   output logic       rsp_is_gga,
   output logic       rsp_ack_in_progress,
   output logic       rsp_has_asterisk,
   output logic [6:0] rsp_line_length
);
   import nlfc_pkg::*;

   localparam int FW = $clog2(LINE_BUF_SIZE + 1);
   localparam int CW = (FW > LEN_W) ? FW : LEN_W;

   logic [FW-1:0] fill_count_ff, fill_count_in;
   logic          collecting_ff, collecting_in;
   logic          asterisk_ff, asterisk_in;
   logic [7:0]    header_ff [HDR_DEPTH];
   logic [7:0]    header_in [HDR_DEPTH];
   logic [7:0]    status_ff, status_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           event_kind_ff, event_kind_in;
   line_class_type line_class_ff, line_class_in;
   logic           is_rmc_ff, is_rmc_in;
   logic           is_gga_ff, is_gga_in;
   logic           ack_ff, ack_in;
   logic           has_ast_ff, has_ast_in;
   logic [6:0]     length_ff, length_in;

   logic          accept;
   logic          emit;
   logic [CW-1:0] fill_wide;
   logic          is_vendor;
   logic          long_enough;

   // A new byte can enter whenever the output register will be free.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign fill_wide = CW'(fill_count_ff);

   assign long_enough = fill_count_ff >= FW'(MIN_LEN);
   assign is_vendor   = ({header_ff[0], header_ff[1], header_ff[2], header_ff[3]} == SIG_PQTM)
                     || ({header_ff[0], header_ff[1], header_ff[2], header_ff[3]} == SIG_PAIR);

   always_comb begin
      fill_count_in = fill_count_ff;
      collecting_in = collecting_ff;
      asterisk_in   = asterisk_ff;
      header_in     = header_ff;
      status_in     = status_ff;
      emit          = 1'b0;
      event_kind_in = EV_LINE;
      line_class_in = LC_INVALID;
      is_rmc_in     = 1'b0;
      is_gga_in     = 1'b0;
      ack_in        = 1'b0;
      has_ast_in    = 1'b0;
      length_in     = '0;

      if (accept) begin
         if (req_rx_byte == CH_DOLLAR) begin
            collecting_in = 1'b1;
            fill_count_in = FW'(1);
            asterisk_in   = 1'b0;
         end else if (req_rx_byte == CH_CR || !collecting_ff) begin
            // Nothing to do: carriage returns and bytes outside a line are dropped.
         end else if (req_rx_byte == CH_LF && fill_count_ff < FW'(LINE_BUF_SIZE)) begin
            emit          = 1'b1;
            collecting_in = 1'b0;
            fill_count_in = '0;
            has_ast_in    = asterisk_ff;
            length_in     = (fill_wide > CW'(LEN_MAX)) ? 7'(LEN_MAX) : fill_wide[6:0];
            if (long_enough) begin
               line_class_in = is_vendor ? LC_VENDOR : LC_STANDARD;
               is_rmc_in = {header_ff[2], header_ff[3], header_ff[4]} == SIG_RMC;
               is_gga_in = {header_ff[2], header_ff[3], header_ff[4]} == SIG_GGA;
               ack_in    = is_vendor && asterisk_ff
                        && fill_count_ff > FW'(STATUS_POS)
                        && {header_ff[0], header_ff[1], header_ff[2], header_ff[3],
                            header_ff[4], header_ff[5], header_ff[6]} == SIG_PAIR001
                        && (status_ff == CH_ZERO || status_ff == CH_ONE);
            end
         end else if (fill_count_ff >= FW'(LINE_BUF_SIZE)) begin
            // The line outgrew the buffer: report once, then wait for '$'.
            emit          = 1'b1;
            event_kind_in = EV_OVERFLOW;
            collecting_in = 1'b0;
         end else begin
            for (int i = 0; i < HDR_DEPTH; i++) begin
               if (fill_count_ff == FW'(i + 1)) begin
                  header_in[i] = req_rx_byte;
               end
            end
            if (fill_count_ff == FW'(STATUS_POS)) begin
               status_in = req_rx_byte;
            end
            if (req_rx_byte == CH_ASTERISK) begin
               asterisk_in = 1'b1;
            end
            fill_count_in = fill_count_ff + FW'(1);
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         collecting_ff <= 1'b0;
         asterisk_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_count_ff <= fill_count_in;
         collecting_ff <= collecting_in;
         asterisk_ff   <= asterisk_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      header_ff <= header_in;
      status_ff <= status_in;
      if (emit) begin
         event_kind_ff <= event_kind_in;
         line_class_ff <= line_class_in;
         is_rmc_ff     <= is_rmc_in;
         is_gga_ff     <= is_gga_in;
         ack_ff        <= ack_in;
         has_ast_ff    <= has_ast_in;
         length_ff     <= length_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_kind      = event_kind_ff;
   assign rsp_line_class      = line_class_ff;
   assign rsp_is_rmc          = is_rmc_ff;
   assign rsp_is_gga          = is_gga_ff;
   assign rsp_ack_in_progress = ack_ff;
   assign rsp_has_asterisk    = has_ast_ff;
   assign rsp_line_length     = length_ff;

`ifndef SYNTHESIS
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= FW'(LINE_BUF_SIZE))
      else $error("line fill count exceeds the buffer size");

   a_overflow_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_OVERFLOW |->
         rsp_line_class == LC_INVALID && rsp_line_length == '0 && !rsp_has_asterisk)
      else $error("overflow result carries line fields");

   a_ack_implies_vendor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ack_in_progress |->
         rsp_line_class == LC_VENDOR && rsp_has_asterisk
         && rsp_line_length > 7'(STATUS_POS))
      else $error("in-progress flag on a line that cannot carry it");

   a_class_vs_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_LINE |->
         (rsp_line_class == LC_INVALID) == (rsp_line_length < 7'(MIN_LEN)))
      else $error("line class disagrees with line length");

   a_emit_after_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(accept))
      else $error("result appeared without a byte transfer");
`endif

endmodule
